// ----- rtl/assert_macros.svh -----
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bia_pkg.sv -----
// shared constants, payload types and control structs of the identifier allocator
package bia_pkg;

    localparam int POOL_SIZE  = 8192;
    localparam int ID_W       = 17;
    localparam int ID_SPAN    = 1 << ID_W;
    localparam logic [ID_W-1:0] BASE_RESET = ID_W'(60000);

    localparam int WORD_W     = (POOL_SIZE < 32) ? POOL_SIZE : 32;
    localparam int NUM_WORDS  = (POOL_SIZE + WORD_W - 1) / WORD_W;
    localparam int IDX_W      = $clog2(POOL_SIZE);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int VC_W       = $clog2(NUM_WORDS + 1);
    localparam int LIM_W      = IDX_W + 1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    localparam logic FUNC_MARK  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] id_value;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] id_out;
        logic [1:0]      status;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic mem_rd;
        logic mark_commit;
        logic scan_commit;
        logic exhaust_commit;
        logic scan_next;
    } ctrl_cmd_t;

    typedef struct packed {
        logic found;
        logic last_visit;
    } dp_sts_t;

endpackage

// ----- rtl/bia_ram.sv -----
// generic single write port ram with registered read
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bia_ctrl.sv -----
// sequencer for mark and allocate requests and the result register valid
module bia_ctrl import bia_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_func,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_sts_t    sts,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MARK_RD  = 3'd1;
    localparam logic [2:0] S_MARK_WR  = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CHK = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       slot_free;
    logic       load;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_func == FUNC_ALLOC) ? S_SCAN_RD : S_MARK_RD;
                end
            end
            S_MARK_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                if (slot_free) begin
                    cmd.mark_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (sts.found) begin
                    if (slot_free) begin
                        cmd.scan_commit = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else if (sts.last_visit) begin
                    if (slot_free) begin
                        cmd.exhaust_commit = 1'b1;
                        state_next         = S_IDLE;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign load = cmd.mark_commit || cmd.scan_commit || cmd.exhaust_commit;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/bia_dp.sv -----
// bitmap store, scan window logic, base register and result payload
module bia_dp import bia_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [ID_W-1:0] cfg_wr_data,
    input  req_t            s_req,
    input  ctrl_cmd_t       cmd,
    output dp_sts_t         sts,
    output rsp_t            rsp
);

    logic [ID_W-1:0]      id_base_reg;
    logic [IDX_W-1:0]     scan_ptr_reg, scan_ptr_next;
    logic [NUM_WORDS-1:0] word_valid_reg, word_valid_next;

    logic [WA_W-1:0]      word_ptr_reg, word_ptr_next;
    logic [BIT_W-1:0]     bit_reg;
    logic [BIT_W-1:0]     start_bit_reg;
    logic                 range_ok_reg;
    logic [LIM_W-1:0]     limit_reg;
    logic [VC_W-1:0]      visit_cnt_reg, visit_cnt_next;
    rsp_t                 rsp_reg;

    logic [ID_W:0]        offset_wide;
    logic [IDX_W-1:0]     mark_idx;
    logic                 in_range;
    logic [ID_W:0]        room;
    logic [LIM_W-1:0]     limit;

    logic [WORD_W-1:0]    rd_data;
    logic [WORD_W-1:0]    cur_word;
    logic [WORD_W-1:0]    start_low;
    logic [WORD_W-1:0]    region;
    logic [WORD_W-1:0]    usable;
    logic [LIM_W-1:0]     limit_word;
    logic [LIM_W-1:0]     word_ext;
    logic [BIT_W-1:0]     limit_bit;
    logic [WORD_W-1:0]    free_bits;
    logic [BIT_W-1:0]     found_bit;
    logic [IDX_W-1:0]     pos;
    logic                 mem_wr;
    logic [WORD_W-1:0]    wr_data;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // request decode at accept
    assign offset_wide = {1'b0, s_req.id_value} - {1'b0, id_base_reg};
    assign mark_idx    = offset_wide[IDX_W-1:0];
    assign in_range    = !offset_wide[ID_W] &&
                         (offset_wide[ID_W-1:0] < ID_W'(POOL_SIZE));
    assign room        = (ID_W+1)'(ID_SPAN) - {1'b0, id_base_reg};
    assign limit       = (room < (ID_W+1)'(POOL_SIZE)) ? LIM_W'(room) : LIM_W'(POOL_SIZE);

    // scan window for the word under test
    assign cur_word   = word_valid_reg[word_ptr_reg] ? rd_data : '0;
    assign start_low  = (WORD_W'(1) << start_bit_reg) - WORD_W'(1);
    assign limit_word = limit_reg >> BIT_W;
    assign limit_bit  = limit_reg[BIT_W-1:0];
    assign word_ext   = LIM_W'(word_ptr_reg);

    always_comb begin
        if (visit_cnt_reg == '0) begin
            region = ~start_low;
        end else if (visit_cnt_reg == VC_W'(NUM_WORDS)) begin
            region = start_low;
        end else begin
            region = '1;
        end
        if (word_ext < limit_word) begin
            usable = '1;
        end else if (word_ext == limit_word) begin
            usable = (WORD_W'(1) << limit_bit) - WORD_W'(1);
        end else begin
            usable = '0;
        end
    end

    assign free_bits      = ~cur_word & usable & region;
    assign found_bit      = lowest_set(free_bits);
    assign pos            = IDX_W'({word_ptr_reg, found_bit});
    assign sts.found      = |free_bits;
    assign sts.last_visit = (visit_cnt_reg == VC_W'(NUM_WORDS));

    assign mem_wr  = (cmd.mark_commit && range_ok_reg) || cmd.scan_commit;
    assign wr_data = cmd.scan_commit ? (cur_word | (WORD_W'(1) << found_bit))
                                     : (cur_word | (WORD_W'(1) << bit_reg));

    bia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (word_ptr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.mem_rd),
        .rd_addr (word_ptr_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        word_valid_next = word_valid_reg;
        if (mem_wr) begin
            word_valid_next[word_ptr_reg] = 1'b1;
        end
        scan_ptr_next = scan_ptr_reg;
        if (cmd.scan_commit) begin
            scan_ptr_next = (pos == IDX_W'(POOL_SIZE - 1)) ? '0 : pos + 1'b1;
        end
        word_ptr_next  = word_ptr_reg;
        visit_cnt_next = visit_cnt_reg;
        if (cmd.accept) begin
            word_ptr_next  = (s_req.func == FUNC_ALLOC) ? WA_W'(scan_ptr_reg >> BIT_W)
                                                         : WA_W'(mark_idx >> BIT_W);
            visit_cnt_next = '0;
        end else if (cmd.scan_next) begin
            word_ptr_next  = (word_ptr_reg == WA_W'(NUM_WORDS - 1)) ? '0
                                                                     : word_ptr_reg + 1'b1;
            visit_cnt_next = visit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_base_reg    <= BASE_RESET;
            scan_ptr_reg   <= '0;
            word_valid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                id_base_reg <= cfg_wr_data;
            end
            scan_ptr_reg   <= scan_ptr_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_ptr_reg  <= word_ptr_next;
        visit_cnt_reg <= visit_cnt_next;
        if (cmd.accept) begin
            bit_reg       <= mark_idx[BIT_W-1:0];
            range_ok_reg  <= in_range;
            start_bit_reg <= scan_ptr_reg[BIT_W-1:0];
            limit_reg     <= limit;
        end
        if (cmd.mark_commit) begin
            rsp_reg.id_out <= '0;
            rsp_reg.status <= range_ok_reg ? ST_DONE : ST_RANGE;
        end else if (cmd.scan_commit) begin
            rsp_reg.id_out <= id_base_reg + ID_W'(pos);
            rsp_reg.status <= ST_DONE;
        end else if (cmd.exhaust_commit) begin
            rsp_reg.id_out <= '0;
            rsp_reg.status <= ST_EXHAUSTED;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- rtl/bitmap_id_allocator.sv -----
// bitmap identifier allocator: one result for every mark or allocate request
//
// requests enter on s_valid/s_ready with s_req (func, id_value); results leave on
// m_valid/m_ready with m_rsp (id_out, status). cfg_wr_en/cfg_wr_data load id_base,
// the identifier of pool index zero; write it only while the block is idle.
// a request walks the bitmap one 32-bit word at a time, reading it from the ram and then testing it:
// a mark visits one word, an allocate starts at the allocation pointer and visits
// k words, k from 1 to 257; a full wrap that finds nothing returns pool exhausted.
// m_valid rises once the last word is tested and the result is registered,
// and s_ready rises with it, as the sequencer returns to idle.
// one request is in flight at a time; s_ready is high only while idle, and the
// next request can be taken while the previous result waits in the output register.
// a stalled receiver holds the result in place and the sequencer waits before
// committing the next one, so nothing is lost or changed.
// reset (aresetn low, synchronous) frees the whole pool at once through per-word
// valid flags, zeroes the pointer, sets id_base to 60000 and drops m_valid.
module bitmap_id_allocator import bia_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [ID_W-1:0] cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  req_t            s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output rsp_t            m_rsp
);

`include "assert_macros.svh"

    ctrl_cmd_t  cmd;
    dp_sts_t    sts;
    logic       s_fire;
    logic       m_failed;
    logic       status_known;
    logic [3:0] cmd_actions;

    bia_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_req.func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bia_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_req       (s_req),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (m_rsp)
    );

    assign s_fire       = s_valid && s_ready;
    assign m_failed     = m_valid && (m_rsp.status != ST_DONE);
    assign status_known = m_rsp.status inside {ST_DONE, ST_RANGE, ST_EXHAUSTED};
    assign cmd_actions  = {cmd.mark_commit, cmd.scan_commit, cmd.exhaust_commit,
                           cmd.scan_next};

    `ASSERT_ALWAYS(a_rst_clears_valid, aclk, !aresetn |=> !m_valid, "m_valid set after reset")
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_fire |=> !s_ready, "taken while busy")
    `ASSERT_CLK(a_one_action, aclk, aresetn, $onehot0(cmd_actions), "conflicting commands")
    `ASSERT_CLK(a_fail_zero_id, aclk, aresetn, m_failed |-> (m_rsp.id_out == '0), "failed id")
    `ASSERT_CLK(a_status_code, aclk, aresetn, m_valid |-> status_known, "undefined status code")

endmodule

// ----- tb/tb_bitmap_id_allocator.sv -----
// self-checking testbench of the bitmap identifier allocator
`timescale 1ns / 100ps

module tb_bitmap_id_allocator import bia_pkg::*; ();

    localparam int LONG_HOLD      = 300;
    localparam int LAST_HOLD_MARK = 1000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_WAIT       = 600;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 150;

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [ID_W-1:0] cfg_wr_data = '0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    req_t            s_req       = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    rsp_t            m_rsp;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    rsp_t        oldest_rsp;

    bit          used_bits[POOL_SIZE];
    int unsigned scan_ptr      = 0;
    int unsigned pool_base     = BASE_RESET;
    bit          idle_on       = 1'b1;

    logic        req_accepted  = 1'b0;
    int          send_gap      = 0;
    int          rsp_gap       = 0;
    int          hold_left     = 0;
    int          hold_mark     = 100;
    int          rsp_count     = 0;
    int          fail_count    = 0;
    int          quiet_cycles  = 0;

    bitmap_id_allocator u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp)
    );

    always #6 aclk = ~aclk;

    function automatic rsp_t predict_rsp(req_t rq);
        rsp_t        r;
        int unsigned val, lim, pos, n;
        bit          hit;
        r.id_out = '0;
        r.status = ST_DONE;
        val      = rq.id_value;
        hit      = 1'b0;
        if (rq.func == FUNC_MARK) begin
            if (val < pool_base || val - pool_base >= POOL_SIZE) begin
                r.status = ST_RANGE;
            end else begin
                used_bits[val - pool_base] = 1'b1;
            end
        end else begin
            lim = ID_SPAN - pool_base;
            if (lim > POOL_SIZE) begin
                lim = POOL_SIZE;
            end
            pos = scan_ptr;
            for (n = 0; n < POOL_SIZE && !hit; n++) begin
                if (pos < lim && !used_bits[pos]) begin
                    hit = 1'b1;
                end else begin
                    pos = (pos + 1 >= POOL_SIZE) ? 0 : pos + 1;
                end
            end
            if (hit) begin
                used_bits[pos] = 1'b1;
                r.id_out       = ID_W'(pool_base + pos);
                scan_ptr       = (pos + 1 >= POOL_SIZE) ? 0 : pos + 1;
            end else begin
                r.status = ST_EXHAUSTED;
            end
        end
        return r;
    endfunction

    function automatic req_t rand_req(int unsigned alloc_pct);
        req_t        rq;
        int unsigned span, pick;
        span    = (ID_SPAN - pool_base < POOL_SIZE) ? ID_SPAN - pool_base : POOL_SIZE;
        rq.func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_MARK;
        pick    = $urandom_range(9);
        if (pick < 3) begin
            rq.id_value = ID_W'($urandom);
        end else if (pick == 3) begin
            rq.id_value = ID_W'(pool_base - 1);
        end else if (pick == 4) begin
            rq.id_value = ID_W'(pool_base + span);
        end else begin
            rq.id_value = ID_W'(pool_base + $urandom_range(span - 1));
        end
        return rq;
    endfunction

    function automatic void enqueue_req(req_t rq);
        pending_reqs = {pending_reqs, rq};
    endfunction

    function automatic void push_req(logic func, int unsigned value);
        req_t rq;
        rq.func     = func;
        rq.id_value = ID_W'(value);
        enqueue_req(rq);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_base(input int unsigned value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ID_W'(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_accepted) begin
            s_valid <= 1'b1;
        end else if (send_gap > 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_reqs.size() != 0) begin
            if (idle_on && $urandom_range(5) == 0) begin
                s_valid  <= 1'b0;
                send_gap <= $urandom_range(15);
            end else begin
                s_req   <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rsp_count >= hold_mark && hold_mark < LAST_HOLD_MARK) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD - 1;
            hold_mark <= hold_mark + 700;
        end else if (rsp_gap > 0) begin
            m_ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
        end else if (idle_on && $urandom_range(9) == 0) begin
            m_ready <= 1'b0;
            rsp_gap <= $urandom_range(15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor, predictor update and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                pool_base = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                rsp_count <= rsp_count + 1;
                if (expected_rsps.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result: id_out %0d status %0d",
                                 m_rsp.id_out, m_rsp.status);
                    end
                    fail_count++;
                end else begin
                    oldest_rsp = expected_rsps.pop_front();
                    if (m_rsp.id_out !== oldest_rsp.id_out ||
                        m_rsp.status !== oldest_rsp.status) begin
                        if (fail_count < 10) begin
                            $display("mismatch: expected id_out %0d status %0d, got %0d %0d",
                                     oldest_rsp.id_out, oldest_rsp.status,
                                     m_rsp.id_out, m_rsp.status);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_rsps = {expected_rsps, predict_rsp(s_req)};
            end
            req_accepted <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("bitmap_id_allocator verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned next_base;
        int unsigned alloc_pct;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset base: first allocations, reuse, both range edges
        push_req(FUNC_ALLOC, $urandom);
        push_req(FUNC_ALLOC, $urandom);
        push_req(FUNC_MARK, BASE_RESET);
        push_req(FUNC_MARK, BASE_RESET - 1);
        push_req(FUNC_MARK, BASE_RESET + POOL_SIZE);
        push_req(FUNC_MARK, ID_SPAN - 1);
        push_req(FUNC_ALLOC, $urandom);

        // sixteen usable entries, run them out
        set_base(ID_SPAN - 16);
        push_req(FUNC_MARK, ID_SPAN - 1);
        push_req(FUNC_MARK, ID_SPAN - 17);
        repeat (13) push_req(FUNC_ALLOC, $urandom);

        // highest base, one usable entry
        set_base(ID_SPAN - 1);
        push_req(FUNC_ALLOC, $urandom);
        push_req(FUNC_MARK, ID_SPAN - 1);
        push_req(FUNC_MARK, ID_SPAN - 2);

        set_base(0);
        push_req(FUNC_MARK, 0);
        push_req(FUNC_MARK, POOL_SIZE);
        push_req(FUNC_MARK, ID_SPAN - 1);
        push_req(FUNC_ALLOC, $urandom);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(4))
                0: next_base = 0;
                1: next_base = ID_SPAN - 1;
                2: next_base = ID_SPAN - $urandom_range(1, 64);
                3: next_base = $urandom_range(ID_SPAN - 1);
                default: next_base = $urandom_range(ID_SPAN - POOL_SIZE);
            endcase
            set_base(next_base);
            idle_on   = ($urandom_range(3) != 0);
            alloc_pct = $urandom_range(30, 70);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                enqueue_req(rand_req(alloc_pct));
            end
        end

        // top index of a pool that ends at the largest identifier
        set_base(ID_SPAN - POOL_SIZE);
        idle_on = 1'b1;
        push_req(FUNC_MARK, ID_SPAN - 1);
        push_req(FUNC_MARK, ID_SPAN - POOL_SIZE - 1);
        push_req(FUNC_ALLOC, $urandom);

        // closing stretch without idling
        set_base($urandom_range(ID_SPAN - 1));
        idle_on = 1'b0;
        for (int k = 0; k < 60; k++) begin
            enqueue_req(rand_req(50));
        end

        wait_idle();
        repeat (END_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("bitmap_id_allocator verification clean");
        end else begin
            $display("bitmap_id_allocator verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bia_pkg.sv
rtl/bia_ram.sv
rtl/bia_ctrl.sv
rtl/bia_dp.sv
rtl/bitmap_id_allocator.sv
tb/tb_bitmap_id_allocator.sv
